>>> hw/rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, constants and tables of the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int PPS_MAX_WAYPOINTS = 256;

	// field widths
	localparam int REG_W   = 31;   // configuration registers, unsigned Q15.16
	localparam int POS_W   = 32;   // positions, signed Q15.16
	localparam int DELTA_W = 33;   // position differences
	localparam int DIST_W  = 34;   // distances out of the hypot unit
	localparam int QUAT_W  = 16;   // quaternion components, Q1.14
	localparam int SPEED_W = 16;   // speeds, Q7.8
	localparam int ANGLE_W = 16;   // internal angles Q13, sines Q14
	localparam int STEER_W = 15;   // steering output, Q1.13
	localparam int IDX_W   = 8;    // target index output
	localparam int QPROD_W = 34;   // quaternion products for the yaw operands
	localparam int NUM_W   = 48;   // 2*L*sin numerator

	// CORDIC datapath
	localparam int CW_W         = 56;
	localparam int ANG_W        = 21;   // Q16 radian accumulator
	localparam int CORDIC_STEPS = 17;
	localparam int STEP_W       = 5;
	localparam int NORM_BIT     = 40;   // operands are scaled up to reach 2^40
	localparam int NORM_COARSE  = 32;   // below 2^32 a shift by 8 stays short of it

	localparam logic signed [ANG_W-1:0]   PI_Q16      = 21'sd205887;
	localparam logic signed [ANG_W-1:0]   HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [ANGLE_W:0]   PI_Q13      = 17'sd25736;
	localparam logic signed [ANGLE_W:0]   TWO_PI_Q13  = 17'sd51472;
	localparam logic signed [ANGLE_W-1:0] STEER_LIMIT = 16'sd12868;
	localparam logic signed [CW_W-1:0]    GAIN_Q30    = 56'sd652032874;
	localparam logic signed [CW_W-1:0]    SIN_LIMIT   = 56'sd16384;
	localparam logic signed [CW_W-1:0]    HALF_Q16    = 56'sd32768;

	// isqrt
	localparam int ROOT_STEPS = 32;
	localparam int ROOT_W     = 5;
	localparam int SQ_W       = 64;

	// configuration reset values
	localparam logic [REG_W-1:0] HORIZON_RST   = 31'd393216;
	localparam logic [REG_W-1:0] WHEELBASE_RST = 31'd122421;
	localparam logic [REG_W-1:0] ARRIVE_RST    = 31'd32768;

	typedef enum logic [1:0] {
		CFG_HORIZON   = 2'd0,
		CFG_WHEELBASE = 2'd1,
		CFG_ARRIVE    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_POSE     = 1'b0,
		MODE_WAYPOINT = 1'b1
	} item_mode_t;

	typedef struct packed {
		logic start;
		logic vec;     // 1: vectoring atan2, 0: rotation sine
	} cordic_req_t;

	typedef enum logic [1:0] {
		C_IDLE,
		C_NORM,
		C_ITER,
		C_FIN
	} cordic_state_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_SQA,
		H_SQB,
		H_ROOT,
		H_FIN
	} hypot_state_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_POSE_N,
		S_POSE_D,
		S_POSE_GO,
		S_POSE_WAIT,
		S_WP,
		S_SEG_WAIT,
		S_WP_END,
		S_TGT_GO,
		S_TGT_WAIT,
		S_ARRIVE,
		S_BEAR_GO,
		S_BEAR_WAIT,
		S_SIN_GO,
		S_SIN_WAIT,
		S_MUL,
		S_STEER_GO,
		S_STEER_WAIT,
		S_DONE
	} seq_state_t;

	// atan(2^-i) in Q16 radians
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] step);
		logic signed [ANG_W-1:0] a;
		unique case (step)
			5'd0:    a = 21'sd51472;
			5'd1:    a = 21'sd30386;
			5'd2:    a = 21'sd16055;
			5'd3:    a = 21'sd8150;
			5'd4:    a = 21'sd4091;
			5'd5:    a = 21'sd2047;
			5'd6:    a = 21'sd1024;
			5'd7:    a = 21'sd512;
			5'd8:    a = 21'sd256;
			5'd9:    a = 21'sd128;
			5'd10:   a = 21'sd64;
			5'd11:   a = 21'sd32;
			5'd12:   a = 21'sd16;
			5'd13:   a = 21'sd8;
			5'd14:   a = 21'sd4;
			5'd15:   a = 21'sd2;
			5'd16:   a = 21'sd1;
			default: a = 21'sd0;
		endcase
		return a;
	endfunction

endpackage

>>> hw/rtl/pps_cordic.sv
// ----------------------------------------------------------------------------
// pps_cordic
// Iterative CORDIC: atan2 by vectoring, sine by rotation, one step a cycle.
// ----------------------------------------------------------------------------
module pps_cordic import pps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cordic_req_t               req,
	input  logic signed [CW_W-1:0]    x_in,
	input  logic signed [CW_W-1:0]    y_in,
	input  logic signed [ANGLE_W-1:0] ang_in,
	output logic                      done,
	output logic signed [ANGLE_W-1:0] result
);

	cordic_state_t state_q, state_d;
	logic signed [CW_W-1:0]  x_q, x_d, y_q, y_d, xs, ys;
	logic signed [ANG_W-1:0] z_q, z_d, za, zr;
	logic [STEP_W-1:0]       i_q, i_d;
	logic                    vec_q, vec_d, up;
	logic [CW_W-1:0]         ax, ay, m;
	logic signed [CW_W-1:0]  yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q   <= x_d;
		y_q   <= y_d;
		z_q   <= z_d;
		i_q   <= i_d;
		vec_q <= vec_d;
	end

	always_comb begin
		state_d = state_q;
		x_d     = x_q;
		y_d     = y_q;
		z_d     = z_q;
		i_d     = i_q;
		vec_d   = vec_q;
		xs      = x_q >>> i_q;
		ys      = y_q >>> i_q;
		up      = vec_q ? !y_q[CW_W-1] : z_q[ANG_W-1];
		ax      = x_q[CW_W-1] ? -x_q : x_q;
		ay      = y_q[CW_W-1] ? -y_q : y_q;
		m       = (ax > ay) ? ax : ay;
		za      = $signed({{(ANG_W-ANGLE_W-3){ang_in[ANGLE_W-1]}}, ang_in, 3'b000});
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					vec_d = req.vec;
					i_d   = '0;
					if (req.vec) begin
						x_d     = x_in;
						y_d     = y_in;
						z_d     = '0;
						state_d = C_NORM;
						if (x_in == '0 && y_in == '0) begin
							state_d = C_FIN;
						end else if (x_in[CW_W-1]) begin
							// pre-rotate by pi into the right half plane
							z_d = y_in[CW_W-1] ? -PI_Q16 : PI_Q16;
							x_d = -x_in;
							y_d = -y_in;
						end
					end else begin
						// fold the angle into [-pi/2, pi/2]
						if (za > HALF_PI_Q16) begin
							z_d = PI_Q16 - za;
						end else if (za < -HALF_PI_Q16) begin
							z_d = -PI_Q16 - za;
						end else begin
							z_d = za;
						end
						x_d     = GAIN_Q30;
						y_d     = '0;
						state_d = C_ITER;
					end
				end
			end
			C_NORM: begin
				if (m[CW_W-1:NORM_BIT] != '0) begin
					state_d = C_ITER;
				end else if (m[NORM_BIT-1:NORM_COARSE] == '0) begin
					x_d = x_q <<< (NORM_BIT - NORM_COARSE);
					y_d = y_q <<< (NORM_BIT - NORM_COARSE);
				end else begin
					x_d = x_q <<< 1;
					y_d = y_q <<< 1;
				end
			end
			C_ITER: begin
				if (up) begin
					x_d = x_q + ys;
					y_d = y_q - xs;
					z_d = z_q + atan_q16(i_q);
				end else begin
					x_d = x_q - ys;
					y_d = y_q + xs;
					z_d = z_q - atan_q16(i_q);
				end
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = C_FIN;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			C_FIN: begin
				state_d = C_IDLE;
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	// round the results: Q16 angle to Q13, Q30 sine to Q14 with clamp
	always_comb begin
		zr = z_q + 21'sd4;
		yr = (y_q + HALF_Q16) >>> 16;
		if (vec_q) begin
			result = ANGLE_W'(zr >>> 3);
		end else if (yr > SIN_LIMIT) begin
			result = ANGLE_W'(SIN_LIMIT);
		end else if (yr < -SIN_LIMIT) begin
			result = ANGLE_W'(-SIN_LIMIT);
		end else begin
			result = ANGLE_W'(yr);
		end
	end

	assign done = (state_q == C_FIN);

endmodule

>>> hw/rtl/pps_hypot.sv
// ----------------------------------------------------------------------------
// pps_hypot
// Distance unit: prescale, two squares, then a bit-pair integer square root.
// ----------------------------------------------------------------------------
module pps_hypot import pps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DELTA_W-1:0] dx,
	input  logic signed [DELTA_W-1:0] dy,
	output logic                      done,
	output logic [DIST_W-1:0]         distance
);

	hypot_state_t state_q, state_d;
	logic [DELTA_W-1:0] a, b, ab;
	logic [1:0]         s_d;
	logic [REG_W-1:0]   a_q, b_q;
	logic [1:0]         s_q;
	logic [SQ_W-1:0]    v_q, r_q, bitv, t;
	logic [ROOT_W-1:0]  k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		a  = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
		b  = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);
		ab = a | b;
		if (ab[DELTA_W-1]) begin
			s_d = 2'd2;
		end else if (ab[DELTA_W-2]) begin
			s_d = 2'd1;
		end else begin
			s_d = 2'd0;
		end
		bitv = SQ_W'(1) << {k_q, 1'b0};
		t    = r_q + bitv;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE:  if (start) state_d = H_SQA;
			H_SQA:   state_d = H_SQB;
			H_SQB:   state_d = H_ROOT;
			H_ROOT:  if (k_q == '0) state_d = H_FIN;
			H_FIN:   state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				a_q <= REG_W'(a >> s_d);
				b_q <= REG_W'(b >> s_d);
				s_q <= s_d;
			end
			H_SQA: begin
				v_q <= SQ_W'(a_q * a_q);
			end
			H_SQB: begin
				v_q <= v_q + SQ_W'(b_q * b_q);
				r_q <= '0;
				k_q <= ROOT_W'(ROOT_STEPS - 1);
			end
			H_ROOT: begin
				if (v_q >= t) begin
					v_q <= v_q - t;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
				k_q <= k_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done     = (state_q == H_FIN);
	assign distance = DIST_W'(r_q[POS_W-1:0]) << s_q;

endmodule

>>> hw/rtl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Pure pursuit controller: pose in, path waypoints in, speed and steering out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): mode 0 loads the vehicle pose and
//   derives yaw from the quaternion; mode 1 delivers one path waypoint, with
//   last set on the final one. Only the last waypoint yields a result item.
//   Output channel (out_valid / out_stall): speed_cmd, steer_angle, arrived,
//   target_index. The result sits in an output register, so the next item
//   is taken while the result still waits for the receiver.
//   Configuration (cfg_valid / cfg_ready): horizon, wheelbase, arrive_radius,
//   always ready; write only while the block is idle.
// Flow: one item at a time, in_stall is high while an item is in work.
//   Pose: the two quaternion products, the CORDIC prescale and 17 CORDIC
//   steps. Waypoint: the segment distance, with the 32-step square
//   root of the distance unit. Last waypoint: a second distance, then, unless
//   the target lies within the arrive radius, three CORDIC passes and one
//   multiply. The CORDIC and the distance unit are each shared by every use.
// Reset: arst_n clears pose, path state and output valid and restores the
//   register defaults. A stalled result holds the block in its final step.
// ----------------------------------------------------------------------------
module pure_pursuit_steering import pps_pkg::*; #(
	parameter int MAX_WAYPOINTS = PPS_MAX_WAYPOINTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [REG_W-1:0]          cfg_data,
	// input items
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [SPEED_W-1:0] speed,
	input  logic signed [QUAT_W-1:0]  quat_x,
	input  logic signed [QUAT_W-1:0]  quat_y,
	input  logic signed [QUAT_W-1:0]  quat_z,
	input  logic signed [QUAT_W-1:0]  quat_w,
	input  logic                      last,
	// result items
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SPEED_W-1:0] speed_cmd,
	output logic signed [STEER_W-1:0] steer_angle,
	output logic                      arrived,
	output logic [IDX_W-1:0]          target_index
);

	localparam int CNT_W = $clog2(MAX_WAYPOINTS);

	seq_state_t state_q, state_d;

	// configuration registers
	logic [REG_W-1:0] horizon_q, wheelbase_q, arrive_q;

	// latched input item
	logic signed [POS_W-1:0]   px_q, py_q;
	logic signed [SPEED_W-1:0] spd_q;
	logic signed [QUAT_W-1:0]  qx_q, qy_q, qz_q, qw_q;
	logic                      last_q;

	// pose and path state
	logic signed [POS_W-1:0]   pose_x_q, pose_y_q, prev_x_q, prev_y_q, tgt_x_q, tgt_y_q;
	logic signed [ANGLE_W-1:0] yaw_q;
	logic [POS_W-1:0]          plen_q;
	logic                      found_q;
	logic [CNT_W-1:0]          tidx_q, cnt_q;
	logic signed [SPEED_W-1:0] first_speed_q;

	// working registers
	logic signed [QPROD_W-1:0] n_q, d_q;
	logic [DIST_W-1:0]         l_q;
	logic signed [ANGLE_W-1:0] ang_q;
	logic signed [NUM_W-1:0]   num_q;

	// pending result and output register
	logic signed [SPEED_W-1:0] res_speed_q, speed_cmd_q;
	logic signed [STEER_W-1:0] res_steer_q, steer_q;
	logic                      res_arrived_q, arrived_q;
	logic [IDX_W-1:0]          res_tidx_q, tidx_out_q;
	logic                      out_valid_q;

	// shared units
	cordic_req_t               cor_req;
	logic signed [CW_W-1:0]    cor_x, cor_y;
	logic                      cor_done;
	logic signed [ANGLE_W-1:0] cor_res;
	logic                      hyp_start, hyp_done;
	logic signed [DELTA_W-1:0] hyp_dx, hyp_dy, tdx, tdy;
	logic [DIST_W-1:0]         hyp_dist;

	logic                      first_wp, out_load;
	logic [POS_W:0]            len_sum;
	logic [POS_W-1:0]          len_new;
	logic signed [ANGLE_W:0]   alpha_raw, alpha_wrap;
	logic signed [ANGLE_W-1:0] theta;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q   <= HORIZON_RST;
			wheelbase_q <= WHEELBASE_RST;
			arrive_q    <= ARRIVE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_HORIZON)   horizon_q   <= cfg_data;
			if (cfg_index == CFG_WHEELBASE) wheelbase_q <= cfg_data;
			if (cfg_index == CFG_ARRIVE)    arrive_q    <= cfg_data;
		end
	end

	// -- datapath helpers ----------------------------------------------------
	assign first_wp = (cnt_q == '0) && !found_q && (plen_q == '0);
	assign tdx      = DELTA_W'(tgt_x_q) - DELTA_W'(pose_x_q);
	assign tdy      = DELTA_W'(tgt_y_q) - DELTA_W'(pose_y_q);
	assign len_sum  = {1'b0, plen_q} + (POS_W+1)'(hyp_dist);
	assign len_new  = (len_sum[POS_W] || (hyp_dist[DIST_W-1:POS_W] != '0)) ? '1
	                : len_sum[POS_W-1:0];
	assign out_load = !out_valid_q || !out_stall;

	// alpha = bearing - yaw, wrapped into [-pi, pi]
	always_comb begin
		alpha_raw = (ANGLE_W+1)'(cor_res) - (ANGLE_W+1)'(yaw_q);
		if (alpha_raw > PI_Q13) begin
			alpha_wrap = alpha_raw - TWO_PI_Q13;
		end else if (alpha_raw < -PI_Q13) begin
			alpha_wrap = alpha_raw + TWO_PI_Q13;
		end else begin
			alpha_wrap = alpha_raw;
		end
		if (cor_res > STEER_LIMIT) begin
			theta = STEER_LIMIT;
		end else if (cor_res < -STEER_LIMIT) begin
			theta = -STEER_LIMIT;
		end else begin
			theta = cor_res;
		end
	end

	// operand selection for the shared units
	always_comb begin
		unique case (state_q)
			S_POSE_GO: begin
				cor_x = CW_W'(d_q);
				cor_y = CW_W'(n_q);
			end
			S_STEER_GO: begin
				cor_x = $signed(CW_W'({l_q, 14'b0}));
				cor_y = CW_W'(num_q);
			end
			default: begin
				cor_x = CW_W'(tdx);
				cor_y = CW_W'(tdy);
			end
		endcase
		if (state_q == S_WP) begin
			hyp_dx = DELTA_W'(px_q) - DELTA_W'(prev_x_q);
			hyp_dy = DELTA_W'(py_q) - DELTA_W'(prev_y_q);
		end else begin
			hyp_dx = tdx;
			hyp_dy = tdy;
		end
	end

	pps_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.x_in   (cor_x),
		.y_in   (cor_y),
		.ang_in (ang_q),
		.done   (cor_done),
		.result (cor_res)
	);

	pps_hypot u_hypot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (hyp_start),
		.dx       (hyp_dx),
		.dy       (hyp_dy),
		.done     (hyp_done),
		.distance (hyp_dist)
	);

	// -- sequencer -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = (state_q != S_IDLE);
		hyp_start     = 1'b0;
		cor_req.start = 1'b0;
		cor_req.vec   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (mode == MODE_POSE) ? S_POSE_N : S_WP;
				end
			end
			S_POSE_N:  state_d = S_POSE_D;
			S_POSE_D:  state_d = S_POSE_GO;
			S_POSE_GO: begin
				cor_req.start = 1'b1;
				state_d       = S_POSE_WAIT;
			end
			S_POSE_WAIT: if (cor_done) state_d = S_IDLE;
			S_WP: begin
				if (first_wp) begin
					state_d = S_WP_END;
				end else begin
					hyp_start = 1'b1;
					state_d   = S_SEG_WAIT;
				end
			end
			S_SEG_WAIT: if (hyp_done) state_d = S_WP_END;
			S_WP_END:   state_d = last_q ? S_TGT_GO : S_IDLE;
			S_TGT_GO: begin
				hyp_start = 1'b1;
				state_d   = S_TGT_WAIT;
			end
			S_TGT_WAIT: if (hyp_done) state_d = S_ARRIVE;
			S_ARRIVE:   state_d = (l_q <= DIST_W'(arrive_q)) ? S_DONE : S_BEAR_GO;
			S_BEAR_GO: begin
				cor_req.start = 1'b1;
				state_d       = S_BEAR_WAIT;
			end
			S_BEAR_WAIT: if (cor_done) state_d = S_SIN_GO;
			S_SIN_GO: begin
				cor_req.start = 1'b1;
				cor_req.vec   = 1'b0;
				state_d       = S_SIN_WAIT;
			end
			S_SIN_WAIT: if (cor_done) state_d = S_MUL;
			S_MUL:      state_d = S_STEER_GO;
			S_STEER_GO: begin
				cor_req.start = 1'b1;
				state_d       = S_STEER_WAIT;
			end
			S_STEER_WAIT: if (cor_done) state_d = S_DONE;
			S_DONE:       if (out_load) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			px_q   <= pos_x;
			py_q   <= pos_y;
			spd_q  <= speed;
			qx_q   <= quat_x;
			qy_q   <= quat_y;
			qz_q   <= quat_z;
			qw_q   <= quat_w;
			last_q <= last;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_POSE_N: begin
				n_q <= (QPROD_W'(qw_q * qz_q) + QPROD_W'(qx_q * qy_q)) <<< 1;
			end
			S_POSE_D: begin
				d_q <= (QPROD_W'(1) <<< 28)
				     - ((QPROD_W'(qy_q * qy_q) + QPROD_W'(qz_q * qz_q)) <<< 1);
			end
			S_TGT_WAIT: if (hyp_done) l_q <= hyp_dist;
			S_BEAR_WAIT: if (cor_done) ang_q <= ANGLE_W'(alpha_wrap);
			S_SIN_WAIT: if (cor_done) ang_q <= cor_res;
			S_MUL: begin
				num_q <= NUM_W'($signed({1'b0, wheelbase_q}) * ang_q) <<< 1;
			end
			default: begin
			end
		endcase
	end

	// pending result
	always_ff @(posedge clk) begin
		if (state_q == S_ARRIVE) begin
			res_tidx_q    <= IDX_W'(tidx_q);
			res_speed_q   <= '0;
			res_steer_q   <= '0;
			res_arrived_q <= 1'b1;
		end
		if (state_q == S_STEER_WAIT && cor_done) begin
			res_speed_q   <= first_speed_q;
			res_steer_q   <= STEER_W'(theta);
			res_arrived_q <= 1'b0;
		end
	end

	// pose and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q      <= '0;
			pose_y_q      <= '0;
			yaw_q         <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			plen_q        <= '0;
			found_q       <= 1'b0;
			tgt_x_q       <= '0;
			tgt_y_q       <= '0;
			tidx_q        <= '0;
			cnt_q         <= '0;
			first_speed_q <= '0;
		end else begin
			unique case (state_q)
				S_POSE_GO: begin
					pose_x_q <= px_q;
					pose_y_q <= py_q;
				end
				S_POSE_WAIT: if (cor_done) yaw_q <= cor_res;
				S_WP: if (first_wp) first_speed_q <= spd_q;
				S_SEG_WAIT: begin
					if (hyp_done) begin
						plen_q <= len_new;
						// latch the first waypoint past the horizon
						if (!found_q && len_new > POS_W'(horizon_q)) begin
							found_q <= 1'b1;
							tgt_x_q <= px_q;
							tgt_y_q <= py_q;
							tidx_q  <= cnt_q;
						end
					end
				end
				S_WP_END: begin
					prev_x_q <= px_q;
					prev_y_q <= py_q;
					if (!last_q) begin
						if (cnt_q < CNT_W'(MAX_WAYPOINTS - 1)) cnt_q <= cnt_q + 1'b1;
					end else if (!found_q) begin
						// no waypoint passed the horizon: aim at the last one
						tgt_x_q <= px_q;
						tgt_y_q <= py_q;
						tidx_q  <= cnt_q;
					end
				end
				S_DONE: begin
					if (out_load) begin
						// start a fresh path after the command
						prev_x_q      <= '0;
						prev_y_q      <= '0;
						plen_q        <= '0;
						found_q       <= 1'b0;
						tgt_x_q       <= '0;
						tgt_y_q       <= '0;
						tidx_q        <= '0;
						cnt_q         <= '0;
						first_speed_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register: hold until the receiver takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_load) begin
			speed_cmd_q <= res_speed_q;
			steer_q     <= res_steer_q;
			arrived_q   <= res_arrived_q;
			tidx_out_q  <= res_tidx_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign speed_cmd    = speed_cmd_q;
	assign steer_angle  = steer_q;
	assign arrived      = arrived_q;
	assign target_index = tidx_out_q;

	// -- assertions ----------------------------------------------------------
	a_arrived_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && arrived |-> speed_cmd == '0 && steer_angle == '0)
		else $error("arrived result carries nonzero command");

	a_steer_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> steer_angle <= STEER_W'(STEER_LIMIT)
			&& steer_angle >= -STEER_W'(STEER_LIMIT))
		else $error("steering angle beyond limit");

	a_path_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_load |=> cnt_q == '0 && !found_q && plen_q == '0)
		else $error("path state not cleared after command");

	a_unit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hyp_done && cor_done))
		else $error("distance unit and CORDIC finished together");

endmodule

>>> test/tb_pure_pursuit_steering.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pure_pursuit_steering
// Self-checking bench: poses and waypoint paths go in, commands are predicted
// bit for bit and compared with each result item in order of arrival.
// ----------------------------------------------------------------------------

// One item of the input channel, one field per port.
typedef struct {
	bit      mode;
	int      px;
	int      py;
	shortint spd;
	shortint qx;
	shortint qy;
	shortint qz;
	shortint qw;
	bit      lst;
} pp_item_t;

// One predicted steering command.
typedef struct {
	logic signed [15:0] speed_cmd;
	logic signed [14:0] steer;
	logic               arrived;
	logic [7:0]         tgt;
} pp_cmd_t;

// Steering predictor plus the queue of commands it still waits for.
class steer_scoreboard;
	longint           atan_tab[17];
	longint unsigned  horizon, wheelbase, arrive_radius;
	longint           pose_x, pose_y, pose_yaw, prev_x, prev_y;
	longint unsigned  path_len;
	bit               tgt_found;
	longint           tgt_x, tgt_y;
	int unsigned      tgt_idx, wp_count;
	longint           first_speed;
	pp_cmd_t          pending[$];
	int               errors, cmds, arrivals;

	function new();
		atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
			128, 64, 32, 16, 8, 4, 2, 1};
		horizon = 393216;
		wheelbase = 122421;
		arrive_radius = 32768;
		pose_x = 0;
		pose_y = 0;
		pose_yaw = 0;
		errors = 0;
		cmds = 0;
		arrivals = 0;
		clear_path();
	endfunction

	function void clear_path();
		prev_x = 0;
		prev_y = 0;
		path_len = 0;
		tgt_found = 0;
		tgt_x = 0;
		tgt_y = 0;
		tgt_idx = 0;
		wp_count = 0;
		first_speed = 0;
	endfunction

	function void set_reg(pps_pkg::cfg_reg_t idx, longint unsigned val);
		case (idx)
			pps_pkg::CFG_HORIZON:   horizon = val;
			pps_pkg::CFG_WHEELBASE: wheelbase = val;
			pps_pkg::CFG_ARRIVE:    arrive_radius = val;
			default: ;
		endcase
	endfunction

	function longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function longint unsigned distance(longint dx, longint dy);
		longint unsigned a, b;
		int s;
		a = dx < 0 ? -dx : dx;
		b = dy < 0 ? -dy : dy;
		s = 0;
		while ((a | b) >= (64'd1 << 31)) begin
			a >>= 1;
			b >>= 1;
			s++;
		end
		return int_root(a * a + b * b) << s;
	endfunction

	// vectoring CORDIC, Q13 radians
	function longint bearing(longint y, longint x);
		longint z, m, xs, ys, ay;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? 205887 : -205887;
			x = -x;
			y = -y;
		end
		ay = y < 0 ? -y : y;
		m = x > ay ? x : ay;
		while (m < (64'sd1 <<< 40)) begin
			x *= 2;
			y *= 2;
			m *= 2;
		end
		for (int i = 0; i < 17; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z += atan_tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z -= atan_tab[i];
			end
		end
		return (z + 4) >>> 3;
	endfunction

	// rotation CORDIC, Q13 angle in, Q14 sine out
	function longint sine(longint a13);
		longint z, x, y, xs, ys, r;
		z = a13 * 8;
		x = 652032874;
		y = 0;
		if (z > 102944)
			z = 205887 - z;
		else if (z < -102944)
			z = -205887 - z;
		for (int i = 0; i < 17; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z -= atan_tab[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z += atan_tab[i];
			end
		end
		r = (y + 32768) >>> 16;
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		return r;
	endfunction

	// Advance the path state by one accepted item; queue a command on last.
	function void note_item(pp_item_t it);
		longint n, d, dx, dy, alpha, num, theta;
		longint unsigned seg, sum, l;
		pp_cmd_t c;
		if (it.mode == pps_pkg::MODE_POSE) begin
			n = 2 * (longint'(it.qw) * it.qz + longint'(it.qx) * it.qy);
			d = (64'sd1 <<< 28) - 2 * (longint'(it.qy) * it.qy + longint'(it.qz) * it.qz);
			pose_x = it.px;
			pose_y = it.py;
			pose_yaw = bearing(n, d);
			return;
		end
		if (wp_count == 0 && !tgt_found && path_len == 0) begin
			first_speed = it.spd;
		end else begin
			seg = distance(longint'(it.px) - prev_x, longint'(it.py) - prev_y);
			sum = path_len + seg;
			path_len = sum > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : sum;
			if (!tgt_found && path_len > horizon) begin
				tgt_found = 1;
				tgt_x = it.px;
				tgt_y = it.py;
				tgt_idx = wp_count;
			end
		end
		prev_x = it.px;
		prev_y = it.py;
		if (!it.lst) begin
			if (wp_count < 255)
				wp_count++;
			return;
		end
		if (!tgt_found) begin
			tgt_x = it.px;
			tgt_y = it.py;
			tgt_idx = wp_count;
		end
		dx = tgt_x - pose_x;
		dy = tgt_y - pose_y;
		l = distance(dx, dy);
		c.tgt = tgt_idx[7:0];
		if (l <= arrive_radius) begin
			c.speed_cmd = 0;
			c.steer = 0;
			c.arrived = 1;
		end else begin
			alpha = bearing(dy, dx) - pose_yaw;
			if (alpha > 25736) alpha -= 51472;
			if (alpha < -25736) alpha += 51472;
			num = 2 * longint'(wheelbase) * sine(alpha);
			theta = bearing(num, longint'(l << 14));
			if (theta > 12868) theta = 12868;
			if (theta < -12868) theta = -12868;
			c.speed_cmd = first_speed[15:0];
			c.steer = theta[14:0];
			c.arrived = 0;
		end
		pending.push_back(c);
		clear_path();
	endfunction

	// Compare one accepted result with the oldest pending command.
	function void check_cmd(pp_cmd_t got);
		pp_cmd_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result spd=%0d steer=%0d arr=%0d idx=%0d",
				$time, got.speed_cmd, got.steer, got.arrived, got.tgt);
			errors++;
			return;
		end
		e = pending.pop_front();
		cmds++;
		if (e.arrived) arrivals++;
		if (got.speed_cmd !== e.speed_cmd) begin
			$display("%0t: speed_cmd exp %0d got %0d", $time, e.speed_cmd, got.speed_cmd);
			errors++;
		end
		if (got.steer !== e.steer) begin
			$display("%0t: steer_angle exp %0d got %0d", $time, e.steer, got.steer);
			errors++;
		end
		if (got.arrived !== e.arrived) begin
			$display("%0t: arrived exp %0d got %0d", $time, e.arrived, got.arrived);
			errors++;
		end
		if (got.tgt !== e.tgt) begin
			$display("%0t: target_index exp %0d got %0d", $time, e.tgt, got.tgt);
			errors++;
		end
	endfunction
endclass

module tb_pure_pursuit_steering;
	import pps_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [REG_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      mode;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic signed [SPEED_W-1:0] speed;
	logic signed [QUAT_W-1:0]  quat_x;
	logic signed [QUAT_W-1:0]  quat_y;
	logic signed [QUAT_W-1:0]  quat_z;
	logic signed [QUAT_W-1:0]  quat_w;
	logic                      last;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [SPEED_W-1:0] speed_cmd;
	logic signed [STEER_W-1:0] steer_angle;
	logic                      arrived;
	logic [IDX_W-1:0]          target_index;

	steer_scoreboard sb;
	bit              idle_on;     // random gaps and stalls on both sides
	int              items_sent;
	int              paths_sent;

	pure_pursuit_steering dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Safety net: the slowest correct run is far below this.
	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: draw a stall for every result, then take the next one.
	initial begin
		int w;
		pp_cmd_t got;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			w = idle_on ? $urandom_range(0, 11) : 0;
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.speed_cmd = speed_cmd;
			got.steer = steer_angle;
			got.arrived = arrived;
			got.tgt = target_index;
			sb.check_cmd(got);
		end
	end

	// Send one item; hold it until accepted, then draw the gap to the next.
	task automatic send(pp_item_t it);
		int g;
		in_valid <= 1'b1;
		mode <= it.mode;
		pos_x <= it.px;
		pos_y <= it.py;
		speed <= it.spd;
		quat_x <= it.qx;
		quat_y <= it.qy;
		quat_z <= it.qz;
		quat_w <= it.qw;
		last <= it.lst;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
		items_sent++;
		g = idle_on ? $urandom_range(0, 11) : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every command is in and the block has settled.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [REG_W-1:0] hz, logic [REG_W-1:0] wb,
			logic [REG_W-1:0] ar);
		drain();
		write_reg(CFG_HORIZON, hz);
		write_reg(CFG_WHEELBASE, wb);
		write_reg(CFG_ARRIVE, ar);
	endtask

	function automatic int rand_pos(int span);
		if (span == 0)
			return int'($urandom);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic shortint rand_quat();
		return shortint'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic pp_item_t pose(int x, int y, shortint qx, shortint qy,
			shortint qz, shortint qw);
		pp_item_t it;
		it.mode = MODE_POSE;
		it.px = x;
		it.py = y;
		it.spd = shortint'($urandom);
		it.qx = qx;
		it.qy = qy;
		it.qz = qz;
		it.qw = qw;
		it.lst = bit'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic pp_item_t waypoint(int x, int y, shortint s, bit lst);
		pp_item_t it;
		it.mode = MODE_WAYPOINT;
		it.px = x;
		it.py = y;
		it.spd = s;
		it.qx = rand_quat();
		it.qy = rand_quat();
		it.qz = rand_quat();
		it.qw = rand_quat();
		it.lst = lst;
		return it;
	endfunction

	// One path of n waypoints with random positions within +-span (0: anywhere).
	task automatic run_path(int n, int span);
		for (int i = 0; i < n; i++)
			send(waypoint(rand_pos(span), rand_pos(span), shortint'($urandom), i == n - 1));
		paths_sent++;
	endtask

	initial begin
		int span, n;
		sb = new();
		idle_on = 1'b0;
		items_sent = 0;
		paths_sent = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = 1'b0;
		pos_x = '0;
		pos_y = '0;
		speed = '0;
		quat_x = '0;
		quat_y = '0;
		quat_z = '0;
		quat_w = '0;
		last = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: quaternion corners, a yaw of atan2(0,0), a waypoint right
		// on the pose, a single-waypoint path, saturating path sum.
		send(pose(0, 0, 0, 0, 0, 0));
		send(waypoint(0, 0, 16'sh7fff, 1'b1));
		send(pose(32'sh7fffffff, 32'sh80000000, 16384, 16384, 16384, 16384));
		send(waypoint(0, 0, -32768, 1'b1));
		send(pose(-65536, 65536, 0, 8192, 8192, 0));
		send(waypoint(65536 * 3, -65536 * 2, 256, 1'b1));
		send(pose(0, 0, -16384, -16384, -16384, -16384));
		send(pose(1000, -1000, 0, 0, 11585, 11585));
		send(waypoint(1000, -1000, -256, 1'b1));
		send(pose(0, 0, 16384, -16384, 0, -16384));
		send(waypoint(32'sh7fffffff, 32'sh7fffffff, 100, 1'b0));
		send(waypoint(32'sh80000000, 32'sh80000000, 200, 1'b0));
		send(waypoint(32'sh7fffffff, 32'sh80000000, 300, 1'b0));
		send(waypoint(32'sh80000000, 32'sh7fffffff, 400, 1'b1));
		send(waypoint(65536 * 2, 0, 512, 1'b0));
		send(waypoint(65536 * 4, 0, 0, 1'b0));
		send(waypoint(65536 * 8, 65536, 0, 1'b0));
		send(waypoint(65536 * 9, 65536 * 9, 0, 1'b1));

		// Long path: the waypoint count saturates while segments keep adding.
		configure(31'h7fffffff, WHEELBASE_RST, ARRIVE_RST);
		for (int i = 0; i < 262; i++)
			send(waypoint(i * 30000, i * 20000, shortint'(i), i == 261));

		// Random phases over register corners; paths are mostly short and
		// local, with the odd pose or wild path between them.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(REG_W'(0), 31'h7fffffff, REG_W'(0));
				1: configure(HORIZON_RST, WHEELBASE_RST, ARRIVE_RST);
				2: configure(31'h7fffffff, REG_W'(0), 31'h7fffffff);
				3: configure(REG_W'(65536 * 2), REG_W'(65536), REG_W'(65536));
				4: configure(REG_W'($urandom_range(0, 65536 * 20)),
					REG_W'($urandom_range(0, 65536 * 4)),
					REG_W'($urandom_range(0, 65536 * 2)));
				default: configure(REG_W'($urandom), REG_W'($urandom),
					REG_W'($urandom_range(0, 65536)));
			endcase
			idle_on = (ph != 1);
			for (int p = 0; p < 16; p++) begin
				if ($urandom_range(0, 3) == 0)
					send(pose(rand_pos(65536 * 10), rand_pos(65536 * 10),
						rand_quat(), rand_quat(), rand_quat(), rand_quat()));
				span = ($urandom_range(0, 9) == 0) ? 0 : 65536 * 12;
				n = $urandom_range(1, 8);
				run_path(n, span);
				// hold off until the pipeline is empty once per phase
				if (p == 10)
					while (sb.pending.size() != 0) begin
						in_valid <= 1'b0;
						@(posedge clk);
					end
			end
		end

		drain();
		$display("Sent %0d items in %0d random paths plus directed ones;", items_sent,
			paths_sent);
		$display("checked %0d commands, %0d of them at the goal.", sb.cmds, sb.arrivals);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
